// ----- sv/mrwt_pkg.sv -----
// Package for the Miller-Rabin witness test unit: widths and word types.
// No dependencies.
`timescale 1ns / 1ps
package mrwt_pkg;
  localparam int unsigned Width = 63;
  localparam int unsigned CntW = $clog2(Width + 1);

  typedef struct packed {
    logic [Width-1:0] modulus;
    logic [Width-1:0] base;
  } in_word_t;

  typedef struct packed {
    logic probable_prime;
    logic bad_modulus;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [Width-1:0] x;
    logic [Width-1:0] y;
    logic [Width-1:0] n;
  } mul_req_t;
endpackage

// ----- sv/mrwt_mulmod.sv -----
// Bit-serial modular multiplier: one bit of y per cycle, double-and-add mod n.
// Depends on mrwt_pkg.
`timescale 1ns / 1ps
module mrwt_mulmod import mrwt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mul_req_t         req_i,
  output logic             done_o,
  output logic [Width-1:0] prod_o
);
  logic [Width-1:0] acc_q, acc_d, y_q, x_q, n_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [Width:0]   dbl, dred, sum, sred;

  always_comb begin
    dbl  = {acc_q, 1'b0};
    dred = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    sum  = dred + {1'b0, x_q};
    sred = (sum >= {1'b0, n_q}) ? sum - {1'b0, n_q} : sum;
    acc_d = y_q[Width-1] ? sred[Width-1:0] : dred[Width-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      n_q   <= req_i.n;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[Width-2:0], 1'b0};
    end
  end

  assign prod_o = acc_q;
endmodule

// ----- sv/miller_rabin_witness_test_unit.sv -----
// Top level of the Miller-Rabin witness test unit: sequencer and result register.
// Depends on mrwt_pkg and mrwt_mulmod.
`timescale 1ns / 1ps
// One verdict per word (modulus n, base a). The unit reduces a mod n by bit-serial
// restoring division, strips the trailing zeros of n-1 one per cycle, then runs
// square-and-multiply over d and up to s-1 further squarings, all on one bit-serial
// modular multiplier. An item needs at most bitlen(d) + popcount(d) + max(s-1, 0)
// products, at most 125 at Width 63; a modulus below 3 goes from acceptance straight
// to the done state, which loads the output register when the output is free. One item
// is in flight at a time: the input stalls from acceptance until the verdict is loaded,
// and also while a loaded verdict is held by a stalled output.
module miller_rabin_witness_test_unit import mrwt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RED  = 8'b00000010,
    S_SPL  = 8'b00000100,
    S_MUL  = 8'b00001000,
    S_SQR  = 8'b00010000,
    S_CHK  = 8'b00100000,
    S_LOOP = 8'b01000000,
    S_DONE = 8'b10000000
  } state_e;

  state_e           state_q;
  logic [Width-1:0] n_q, a_q, d_q, res_q, sq_q, nm1;
  logic [Width-1:0] rem_q, rem_d;
  logic [CntW-1:0]  s_q, bit_q;
  logic             wait_q, verdict_q;
  mul_req_t         req;
  logic             mdone;
  logic [Width-1:0] prod;
  logic [Width:0]   trial, tdiff;

  mrwt_mulmod u_mul (.clk_i, .rst_ni, .req_i(req), .done_o(mdone), .prod_o(prod));

  assign nm1   = n_q - 1'b1;
  assign trial = {rem_q, a_q[Width-1]};
  assign tdiff = trial - {1'b0, n_q};
  assign rem_d = (trial >= {1'b0, n_q}) ? tdiff[Width-1:0] : trial[Width-1:0];
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_o && out_stall_i);

  always_comb begin
    req = '0;
    req.n = n_q;
    if (!wait_q) begin
      if (state_q == S_MUL && d_q[0]) begin
        req.start = 1'b1; req.x = res_q; req.y = sq_q;
      end else if (state_q == S_SQR || state_q == S_LOOP) begin
        req.start = 1'b1;
        req.x = (state_q == S_SQR) ? sq_q : res_q;
        req.y = req.x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
      n_q         <= '0;
      a_q         <= '0;
      d_q         <= '0;
      res_q       <= '0;
      sq_q        <= '0;
      rem_q       <= '0;
      s_q         <= '0;
      bit_q       <= '0;
      verdict_q   <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_o || !out_stall_i)) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (req.start) wait_q <= 1'b1;
      else if (mdone) wait_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            n_q <= in_data_i.modulus; a_q <= in_data_i.base;
            rem_q <= '0; bit_q <= CntW'(Width); s_q <= '0;
            state_q <= (in_data_i.modulus < Width'(3)) ? S_DONE : S_RED;
            verdict_q <= 1'b0;
          end
        end
        S_RED: begin
          rem_q <= rem_d;
          a_q   <= {a_q[Width-2:0], 1'b0};
          bit_q <= bit_q - 1'b1;
          if (bit_q == CntW'(1)) begin
            d_q <= nm1; state_q <= S_SPL;
          end
        end
        S_SPL: begin
          sq_q <= rem_q; res_q <= Width'(1);
          if (n_q[0] && !d_q[0]) begin
            d_q <= d_q >> 1; s_q <= s_q + 1'b1;
          end else state_q <= S_MUL;
        end
        S_MUL: begin
          if (!d_q[0]) state_q <= S_SQR;
          else if (mdone) begin res_q <= prod; state_q <= S_SQR; end
        end
        S_SQR: begin
          if (mdone) begin
            sq_q <= prod; d_q <= d_q >> 1;
            state_q <= (d_q[Width-1:1] == '0) ? S_CHK : S_MUL;
          end
        end
        S_CHK: begin
          if (res_q == Width'(1) || res_q == nm1) begin
            verdict_q <= 1'b1; state_q <= S_DONE;
          end else if (s_q <= CntW'(1)) state_q <= S_DONE;
          else begin s_q <= s_q - 1'b1; state_q <= S_LOOP; end
        end
        S_LOOP: begin
          if (mdone) begin
            res_q <= prod;
            if (prod == nm1) begin verdict_q <= 1'b1; state_q <= S_DONE; end
            else if (prod == Width'(1) || s_q <= CntW'(1)) state_q <= S_DONE;
            else s_q <= s_q - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_o || !out_stall_i) begin
            out_data_o.probable_prime <= verdict_q && (n_q >= Width'(3));
            out_data_o.bad_modulus    <= n_q < Width'(3);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bad_no_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.bad_modulus && out_data_o.probable_prime))
    else $error("bad modulus with prime verdict");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !wait_q) else $error("multiplier restarted while busy");
  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone |-> wait_q) else $error("product without request");
`endif
endmodule

// ----- tb/sv/mrwt_verdict_checker.sv -----
// Verdict checker for the Miller-Rabin witness test unit: watches both channels,
// predicts each verdict with its own modular arithmetic and compares. Depends on mrwt_pkg.
`timescale 1ns / 1ps
module mrwt_verdict_checker import mrwt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_data_i,
  output int        errors_o,
  output int        pending_o
);
  out_word_t verdict_q[$];
  int        err_cnt = 0;

  function automatic logic [Width-1:0] mul_mod(logic [Width-1:0] x, logic [Width-1:0] y,
                                               logic [Width-1:0] n);
    logic [2*Width-1:0] prod;
    prod = {{Width{1'b0}}, x} * {{Width{1'b0}}, y};
    return Width'(prod % {{Width{1'b0}}, n});
  endfunction

  function automatic out_word_t predict_verdict(in_word_t w);
    logic [Width-1:0] n, d, x, sq;
    int               s;
    out_word_t        v;
    n = w.modulus;
    v = '0;
    if (n < 3) begin
      v.bad_modulus = 1'b1;
      return v;
    end
    d = n - 1;
    s = 0;
    while (d != 0 && !d[0]) begin
      d = d >> 1;
      s++;
    end
    x = 1;
    sq = w.base % n;
    while (d != 0) begin
      if (d[0]) x = mul_mod(x, sq, n);
      sq = mul_mod(sq, sq, n);
      d = d >> 1;
    end
    if (x == 1 || x == n - 1) begin
      v.probable_prime = 1'b1;
      return v;
    end
    for (int i = 1; i < s; i++) begin
      x = mul_mod(x, x, n);
      if (x == n - 1) begin
        v.probable_prime = 1'b1;
        return v;
      end
      if (x == 1) return v;
    end
    return v;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  assign errors_o  = err_cnt;
  assign pending_o = verdict_q.size();

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) verdict_q.push_back(predict_verdict(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report("verdict word with none expected");
        end else begin
          exp_w = verdict_q.pop_front();
          if (out_data_i.probable_prime !== exp_w.probable_prime)
            report($sformatf("probable_prime %b, expected %b",
                             out_data_i.probable_prime, exp_w.probable_prime));
          if (out_data_i.bad_modulus !== exp_w.bad_modulus)
            report($sformatf("bad_modulus %b, expected %b",
                             out_data_i.bad_modulus, exp_w.bad_modulus));
        end
      end
    end
  end
endmodule

// ----- tb/sv/miller_rabin_witness_test_unit_tb.sv -----
// Testbench top for the Miller-Rabin witness test unit: clock, reset, directed and
// random words under varying idle patterns. Depends on mrwt_pkg, the unit and the checker.
`timescale 1ns / 1ps
module miller_rabin_witness_test_unit_tb;
  import mrwt_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;
  int        errors;
  int        pending;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_cycles = 0;

  always #5 clk_i = ~clk_i;

  miller_rabin_witness_test_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  mrwt_verdict_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .errors_o(errors), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [Width-1:0] rand_field();
    return Width'({$urandom, $urandom});
  endfunction

  task automatic send_word(logic [Width-1:0] n, logic [Width-1:0] a);
    in_word_t w;
    w.modulus = n;
    w.base = a;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [Width-1:0] n, a;
    int               kind;
    kind = $urandom_range(9);
    n = rand_field();
    a = rand_field();
    case (kind)
      0: ;
      1: n = $urandom_range(2);
      2: n[0] = 1'b0;
      3: n = ($urandom_range(50000) << 1) | 1;
      default: begin
        n[0] = 1'b1;
        if (n < 5) n = 5;
        a = 2 + (a % (n - 3));
      end
    endcase
    if (kind == 3) a = 2 + (a % (n > 4 ? n - 3 : 1));
    send_word(n, a);
  endtask

  initial begin
    logic [Width-1:0] mx;
    mx = '1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 78;
    send_word(0, 5);
    send_word(1, mx);
    send_word(2, 0);
    send_word(3, 2);
    send_word(5, 5);
    send_word(7, 14);
    send_word(561, 2);
    send_word(2047, 2);
    send_word(2047, 3);
    send_word(1000000007, 123456789);
    send_word(63'h1FFF_FFFF_FFFF_FFFF, 3);
    send_word(63'h1FFF_FFFF_FFFF_FFFF, mx);
    send_word(mx, mx);
    send_word(mx, 0);
    send_word(mx - 1, 2);
    send_word(63'h7FFF_FFFF_FFFF_FFE7, 63'h7FFF_FFFF_FFFF_FFE6);
    send_word(63'h7FFF_FFFF_FFFF_FFE7, 1);
    send_word(100, 99);
    send_word(3215031751, 2);
    send_word(1000000007, 2000000014);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);

    for (int i = 0; i < 27; i++) send_random();
    hold_cycles = 40000;
    send_idle_pct = 78;
    recv_idle_pct = 21;
    for (int i = 0; i < 27; i++) send_random();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 26; i++) send_random();
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (200) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
